### sv/sleep_entry_wake_controller_unit_macros.svh
// Assertion macros shared by the checker of the sleep entry and wake controller.
`ifndef SLEEP_ENTRY_WAKE_CONTROLLER_UNIT_MACROS_SVH
`define SLEEP_ENTRY_WAKE_CONTROLLER_UNIT_MACROS_SVH

// Checked only outside reset.
`define SWC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every edge, reset included.
`define SWC_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### sv/swc_pkg.sv
// Types, codes and constants of the sleep entry and wake controller.
`timescale 1ns / 1ps

package swc_pkg;

  localparam int TEMP_BITS = 12;
  // Signed width that holds a difference of two temperatures and every threshold.
  localparam int CMP_W = (TEMP_BITS + 1 > 13) ? TEMP_BITS + 1 : 13;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 32;

  typedef logic signed [TEMP_BITS-1:0] temp_t;

  typedef enum logic [1:0] {
    CAUSE_NONE      = 2'd0,
    CAUSE_LONGPRESS = 2'd1,
    CAUSE_STABLE    = 2'd2
  } cause_t;

  typedef enum logic [2:0] {
    REASON_NONE = 3'd0,
    REASON_UART = 3'd1,
    REASON_RTC  = 3'd2,
    REASON_BTN  = 3'd3,
    REASON_IMU  = 3'd4,
    REASON_TEMP = 3'd5
  } wake_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_STABLE_RANGE    = 3'd0,
    REG_STABLE_TIME_MS  = 3'd1,
    REG_TEMP_WAKE_DELTA = 3'd2,
    REG_LONGPRESS_MS    = 3'd3,
    REG_RTC_WAKE_ENABLE = 3'd4
  } cfg_idx_t;

  typedef struct packed {
    logic [7:0]  stable_range;
    logic [31:0] stable_time_ms;
    logic [11:0] temp_wake_delta;
    logic [15:0] longpress_ms;
    logic        rtc_wake_enable;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    stable_range:    8'd10,
    stable_time_ms:  32'd60000,
    temp_wake_delta: 12'd10,
    longpress_ms:    16'd3000,
    rtc_wake_enable: 1'b0
  };

  typedef struct packed {
    logic [31:0] now_ms;
    temp_t       temperature;
    logic        button_held;
    logic        button_press_event;
    logic        uart_rx_pending;
    logic        rtc_fired;
    logic        imu_int;
    logic [15:0] elapsed_ms;
  } in_item_t;

  typedef struct packed {
    logic        asleep_now;
    logic        enter_sleep;
    cause_t      sleep_cause;
    wake_t       wake_reason;
    logic [31:0] asleep_total_ms;
  } res_t;

endpackage

### sv/swc_ifs.sv
// Channel interfaces of the sleep entry and wake controller.
`timescale 1ns / 1ps

interface swc_in_if;
  logic               valid;
  logic               ready;
  logic [31:0]        now_ms;
  swc_pkg::temp_t     temperature;
  logic               button_held;
  logic               button_press_event;
  logic               uart_rx_pending;
  logic               rtc_fired;
  logic               imu_int;
  logic [15:0]        elapsed_ms;

  modport source (output valid, now_ms, temperature, button_held, button_press_event,
                  uart_rx_pending, rtc_fired, imu_int, elapsed_ms, input ready);
  modport sink (input valid, now_ms, temperature, button_held, button_press_event,
                uart_rx_pending, rtc_fired, imu_int, elapsed_ms, output ready);
endinterface

interface swc_out_if;
  logic        valid;
  logic        ready;
  logic        asleep_now;
  logic        enter_sleep;
  logic [1:0]  sleep_cause;
  logic [2:0]  wake_reason;
  logic [31:0] asleep_total_ms;

  modport source (output valid, asleep_now, enter_sleep, sleep_cause, wake_reason,
                  asleep_total_ms, input ready);
  modport sink (input valid, asleep_now, enter_sleep, sleep_cause, wake_reason,
                asleep_total_ms, output ready);
endinterface

interface swc_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [swc_pkg::CFG_IDX_W-1:0]   index;
  logic [swc_pkg::CFG_DATA_W-1:0]  data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

### sv/swc_cfg_regs.sv
// Configuration register file of the sleep entry and wake controller.
`timescale 1ns / 1ps

module swc_cfg_regs (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           wr_en,
  input  logic [swc_pkg::CFG_IDX_W-1:0]  wr_index,
  input  logic [swc_pkg::CFG_DATA_W-1:0] wr_data,
  output swc_pkg::cfg_t                  cfg
);

  swc_pkg::cfg_t cfg_r, cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (swc_pkg::cfg_idx_t'(wr_index))
        swc_pkg::REG_STABLE_RANGE:    cfg_nxt.stable_range    = wr_data[7:0];
        swc_pkg::REG_STABLE_TIME_MS:  cfg_nxt.stable_time_ms  = wr_data[31:0];
        swc_pkg::REG_TEMP_WAKE_DELTA: cfg_nxt.temp_wake_delta = wr_data[11:0];
        swc_pkg::REG_LONGPRESS_MS:    cfg_nxt.longpress_ms    = wr_data[15:0];
        swc_pkg::REG_RTC_WAKE_ENABLE: cfg_nxt.rtc_wake_enable = wr_data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= swc_pkg::CFG_RESET;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

### sv/swc_step.sv
// Controller state and the single-pass update logic for one item.
`timescale 1ns / 1ps

module swc_step (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              fire,
  input  swc_pkg::in_item_t item,
  input  swc_pkg::cfg_t     cfg,
  output swc_pkg::res_t     res
);

  localparam int CW = swc_pkg::CMP_W;

  logic           asleep_r, asleep_nxt;
  logic           armed_r, armed_nxt;
  swc_pkg::temp_t win_min_r, win_min_nxt;
  swc_pkg::temp_t win_max_r, win_max_nxt;
  logic [31:0]    win_start_r, win_start_nxt;
  swc_pkg::temp_t entry_r, entry_nxt;
  logic [31:0]    total_r, total_nxt;
  logic           timer_r, timer_nxt;
  logic [31:0]    press_start_r, press_start_nxt;
  logic           pending_r, pending_nxt;

  logic                 expire;
  logic                 pend_now;
  swc_pkg::temp_t       t;
  swc_pkg::temp_t       new_min, new_max;
  logic signed [CW-1:0] spread, dlt, adlt;
  logic [32:0]          sum;
  swc_pkg::wake_t       reason;
  swc_pkg::cause_t      cause;
  logic                 entered;

  always_comb begin
    t               = item.temperature;
    asleep_nxt      = asleep_r;
    armed_nxt       = armed_r;
    win_min_nxt     = win_min_r;
    win_max_nxt     = win_max_r;
    win_start_nxt   = win_start_r;
    entry_nxt       = entry_r;
    total_nxt       = total_r;
    timer_nxt       = timer_r;
    press_start_nxt = press_start_r;
    pending_nxt     = pending_r;
    reason          = swc_pkg::REASON_NONE;
    cause           = swc_pkg::CAUSE_NONE;
    entered         = 1'b0;

    // Long-press timer: expiry is judged before a new press restarts it.
    expire   = timer_r && ((item.now_ms - press_start_r) >= 32'(cfg.longpress_ms));
    pend_now = pending_r || (expire && item.button_held);

    new_min = (t < win_min_r) ? t : win_min_r;
    new_max = (t > win_max_r) ? t : win_max_r;
    spread  = CW'(new_max) - CW'(new_min);

    dlt  = CW'(t) - CW'(entry_r);
    adlt = dlt[CW-1] ? -dlt : dlt;
    sum  = {1'b0, total_r} + 33'(item.elapsed_ms);

    if (!asleep_r) begin
      if (expire) begin
        timer_nxt = 1'b0;
      end
      if (item.button_press_event) begin
        timer_nxt       = 1'b1;
        press_start_nxt = item.now_ms;
      end
      if (pend_now) begin
        pending_nxt = 1'b0;
        entered     = 1'b1;
        cause       = swc_pkg::CAUSE_LONGPRESS;
      end else if (!armed_r) begin
        pending_nxt   = pend_now;
        win_min_nxt   = t;
        win_max_nxt   = t;
        win_start_nxt = item.now_ms;
        armed_nxt     = 1'b1;
      end else begin
        win_min_nxt = new_min;
        win_max_nxt = new_max;
        if (spread > $signed(CW'(cfg.stable_range))) begin
          win_min_nxt   = t;
          win_max_nxt   = t;
          win_start_nxt = item.now_ms;
        end else if ((item.now_ms - win_start_r) >= cfg.stable_time_ms) begin
          entered = 1'b1;
          cause   = swc_pkg::CAUSE_STABLE;
        end
      end
      if (entered) begin
        asleep_nxt = 1'b1;
        entry_nxt  = t;
        total_nxt  = '0;
        armed_nxt  = 1'b0;
      end
    end else begin
      total_nxt = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
      if (item.uart_rx_pending) begin
        reason = swc_pkg::REASON_UART;
      end else if (cfg.rtc_wake_enable && item.rtc_fired) begin
        reason = swc_pkg::REASON_RTC;
      end else if (item.button_held) begin
        reason = swc_pkg::REASON_BTN;
      end else if (item.imu_int) begin
        reason = swc_pkg::REASON_IMU;
      end else if (adlt >= $signed(CW'(cfg.temp_wake_delta))) begin
        reason = swc_pkg::REASON_TEMP;
      end
      if (reason != swc_pkg::REASON_NONE) begin
        asleep_nxt = 1'b0;
        armed_nxt  = 1'b0;
      end
    end

    res.asleep_now      = asleep_nxt;
    res.enter_sleep     = entered;
    res.sleep_cause     = cause;
    res.wake_reason     = reason;
    res.asleep_total_ms = total_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      asleep_r      <= 1'b0;
      armed_r       <= 1'b0;
      win_min_r     <= '0;
      win_max_r     <= '0;
      win_start_r   <= '0;
      entry_r       <= '0;
      total_r       <= '0;
      timer_r       <= 1'b0;
      press_start_r <= '0;
      pending_r     <= 1'b0;
    end else if (fire) begin
      asleep_r      <= asleep_nxt;
      armed_r       <= armed_nxt;
      win_min_r     <= win_min_nxt;
      win_max_r     <= win_max_nxt;
      win_start_r   <= win_start_nxt;
      entry_r       <= entry_nxt;
      total_r       <= total_nxt;
      timer_r       <= timer_nxt;
      press_start_r <= press_start_nxt;
      pending_r     <= pending_nxt;
    end
  end

endmodule

### sv/sleep_entry_wake_controller_unit.sv
// Top level of the sleep entry and wake controller: input and result registers.
//
//   Channel  Dir  Handshake       Transaction
//   in_ch    in   valid / ready   one poll while active, or one low-power leg while asleep
//   out_ch   out  valid / ready   one result per input transaction, in order
//   cfg_ch   in   valid / ready   one register write (index, data); ready is always high
//
// An input transaction is captured in the input register and evaluated there by
// single-pass logic against the controller state; its result is written to the
// result register when the held item advances, which raises out_ch.valid. A new
// transaction is accepted in every cycle unless out_ch stalls; the state update of one
// item and the capture of the next happen at the same edge. When out_ch stalls, the
// result is held and one more transaction may wait in the input register before
// in_ch.ready drops.
// Reset is synchronous and active low; it restores the register defaults and the
// active, disarmed, idle-timer state.
`timescale 1ns / 1ps

module sleep_entry_wake_controller_unit (
  input  logic   clk,
  input  logic   rst_n,
  swc_in_if.sink    in_ch,
  swc_out_if.source out_ch,
  swc_cfg_if.sink   cfg_ch
);

  swc_pkg::cfg_t     cfg;
  swc_pkg::in_item_t in_item_r;
  logic              in_v_r, in_v_nxt;
  swc_pkg::res_t     res;
  swc_pkg::res_t     res_r;
  logic              out_v_r, out_v_nxt;
  logic              advance;
  logic              in_take;

  // Configuration writes are always taken; the user writes only while idle.
  assign cfg_ch.ready = 1'b1;

  swc_cfg_regs u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_ch.valid),
    .wr_index (cfg_ch.index),
    .wr_data  (cfg_ch.data),
    .cfg      (cfg)
  );

  // The held item moves on whenever the result register is empty or being drained.
  assign advance     = in_v_r && (!out_v_r || out_ch.ready);
  assign in_ch.ready = !in_v_r || advance;
  assign in_take     = in_ch.valid && in_ch.ready;

  always_comb begin
    in_v_nxt  = in_take ? 1'b1 : (advance ? 1'b0 : in_v_r);
    out_v_nxt = advance ? 1'b1 : ((out_v_r && out_ch.ready) ? 1'b0 : out_v_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      in_v_r  <= in_v_nxt;
      out_v_r <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      in_item_r.now_ms             <= in_ch.now_ms;
      in_item_r.temperature        <= in_ch.temperature;
      in_item_r.button_held        <= in_ch.button_held;
      in_item_r.button_press_event <= in_ch.button_press_event;
      in_item_r.uart_rx_pending    <= in_ch.uart_rx_pending;
      in_item_r.rtc_fired          <= in_ch.rtc_fired;
      in_item_r.imu_int            <= in_ch.imu_int;
      in_item_r.elapsed_ms         <= in_ch.elapsed_ms;
    end
    if (advance) begin
      res_r <= res;
    end
  end

  swc_step u_step (
    .clk   (clk),
    .rst_n (rst_n),
    .fire  (advance),
    .item  (in_item_r),
    .cfg   (cfg),
    .res   (res)
  );

  assign out_ch.valid           = out_v_r;
  assign out_ch.asleep_now      = res_r.asleep_now;
  assign out_ch.enter_sleep     = res_r.enter_sleep;
  assign out_ch.sleep_cause     = res_r.sleep_cause;
  assign out_ch.wake_reason     = res_r.wake_reason;
  assign out_ch.asleep_total_ms = res_r.asleep_total_ms;

endmodule

### sv/swc_checker.sv
// Port-level checker of the sleep entry and wake controller, with its bind.
`timescale 1ns / 1ps
`include "sleep_entry_wake_controller_unit_macros.svh"

module swc_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic        out_asleep_now,
  input logic        out_enter_sleep,
  input logic [1:0]  out_sleep_cause,
  input logic [2:0]  out_wake_reason,
  input logic [31:0] out_asleep_total_ms
);

  logic [38:0] out_payload;
  logic        has_cause;
  logic        has_wake;
  logic        entry_ok;

  assign out_payload = {out_asleep_now, out_enter_sleep, out_sleep_cause, out_wake_reason,
                        out_asleep_total_ms};
  assign has_cause   = (out_sleep_cause != swc_pkg::CAUSE_NONE);
  assign has_wake    = (out_wake_reason != swc_pkg::REASON_NONE);
  assign entry_ok    = (out_enter_sleep == has_cause) && (!out_enter_sleep || out_asleep_now);

  // A stalled result keeps its contents.
  `SWC_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(out_payload), "result changed while stalled")

  // Sleep entry always names a cause and leaves the block asleep.
  `SWC_ASSERT(a_entry_cause, out_valid |-> entry_ok, "sleep entry and cause disagree")

  // A wake never comes with a sleep entry, and the block is active after it.
  `SWC_ASSERT(a_wake_active, out_valid && has_wake |-> !out_asleep_now && !out_enter_sleep, "bad wake")

  // A fresh sleep starts its total at zero.
  `SWC_ASSERT(a_entry_total, out_valid && out_enter_sleep |-> out_asleep_total_ms == '0, "entry total")

  // No result is shown in the cycle after a reset edge.
  `SWC_ASSERT_ALWAYS(a_reset_idle, !rst_n |=> !out_valid, "result valid after reset")

endmodule

bind sleep_entry_wake_controller_unit swc_checker u_swc_checker (
  .clk                 (clk),
  .rst_n               (rst_n),
  .out_valid           (out_ch.valid),
  .out_ready           (out_ch.ready),
  .out_asleep_now      (out_ch.asleep_now),
  .out_enter_sleep     (out_ch.enter_sleep),
  .out_sleep_cause     (out_ch.sleep_cause),
  .out_wake_reason     (out_ch.wake_reason),
  .out_asleep_total_ms (out_ch.asleep_total_ms)
);

### verif/tb_sleep_entry_wake_controller_unit.sv
// Self-checking testbench of the sleep entry and wake controller unit.
`timescale 1ns / 1ps

module tb_sleep_entry_wake_controller_unit;

  // Cycle budget for the whole run.
  localparam int unsigned CYCLE_LIMIT = 1000000;
  // Cycles allowed after the last result before a register write or the end.
  localparam int DRAIN_CYCLES = 4;
  // Length of the long receiver stall that fills the block.
  localparam int HOLD_CYCLES = 300;
  localparam int T_MAX = 2 ** (swc_pkg::TEMP_BITS - 1) - 1;
  localparam int T_MIN = -(2 ** (swc_pkg::TEMP_BITS - 1));

  logic clk = 1'b0;
  logic rst_n;

  swc_in_if  in_ch();
  swc_out_if out_ch();
  swc_cfg_if cfg_ch();

  sleep_entry_wake_controller_unit dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  always #5 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Controller state as the testbench predicts it. The predictor and the
  // register copy are updated by the process that owns the handshake, right
  // after the accepting edge, so the stimulus generator can read them safely.
  // ---------------------------------------------------------------------------
  swc_pkg::cfg_t ctl_cfg        = swc_pkg::CFG_RESET;
  bit            ctl_asleep     = 1'b0;
  bit            ctl_win_armed  = 1'b0;
  int            ctl_win_lo     = 0;
  int            ctl_win_hi     = 0;
  logic [31:0]   ctl_win_t0     = '0;
  int            ctl_entry_temp = 0;
  logic [31:0]   ctl_total      = '0;
  bit            ctl_press_run  = 1'b0;
  logic [31:0]   ctl_press_t0   = '0;
  bit            ctl_pending    = 1'b0;

  // Expected result of every accepted transaction, oldest first.
  swc_pkg::res_t predicted_status[$];
  swc_pkg::res_t exp_status;

  int unsigned mismatches  = 0;
  int unsigned cycle_count = 0;

  // Idle rates in percent. The receiver rate is changed with a nonblocking
  // assignment so the receiver process sees it at a well defined edge.
  int  snd_idle_pct = 0;
  int  rcv_idle_pct = 0;
  logic rx_hold = 1'b0;
  event hold_kick;

  // Stimulus generator state: running millisecond tick, the temperature the
  // random readings hover around, and how many polls a press is still held.
  logic [31:0] gen_now   = '0;
  int          gen_base  = 200;
  int          hold_left = 0;
  logic [31:0] step_max  = 32'd1000;

  // Sleep entry records the temperature, clears the total and drops the window.
  function automatic void enter_low_power(int t);
    ctl_asleep     = 1'b1;
    ctl_entry_temp = t;
    ctl_total      = '0;
    ctl_win_armed  = 1'b0;
  endfunction

  // Applies one input transaction to the predicted state and returns the result.
  function automatic swc_pkg::res_t predict_status(swc_pkg::in_item_t it);
    swc_pkg::res_t r;
    logic [31:0]   since;
    logic [32:0]   sum;
    int            t;
    int            d;
    r             = '0;
    r.sleep_cause = swc_pkg::CAUSE_NONE;
    r.wake_reason = swc_pkg::REASON_NONE;
    t             = int'(it.temperature);
    if (!ctl_asleep) begin
      // The long-press timer is checked before the new press and the poll.
      since = it.now_ms - ctl_press_t0;
      if (ctl_press_run && since >= 32'(ctl_cfg.longpress_ms)) begin
        ctl_press_run = 1'b0;
        if (it.button_held) ctl_pending = 1'b1;
      end
      if (it.button_press_event) begin
        ctl_press_run = 1'b1;
        ctl_press_t0  = it.now_ms;
      end
      if (ctl_pending) begin
        ctl_pending = 1'b0;
        enter_low_power(t);
        r.enter_sleep = 1'b1;
        r.sleep_cause = swc_pkg::CAUSE_LONGPRESS;
      end else if (!ctl_win_armed) begin
        ctl_win_lo    = t;
        ctl_win_hi    = t;
        ctl_win_t0    = it.now_ms;
        ctl_win_armed = 1'b1;
      end else begin
        if (t < ctl_win_lo) ctl_win_lo = t;
        if (t > ctl_win_hi) ctl_win_hi = t;
        since = it.now_ms - ctl_win_t0;
        if (ctl_win_hi - ctl_win_lo > int'(ctl_cfg.stable_range)) begin
          ctl_win_lo = t;
          ctl_win_hi = t;
          ctl_win_t0 = it.now_ms;
        end else if (since >= ctl_cfg.stable_time_ms) begin
          enter_low_power(t);
          r.enter_sleep = 1'b1;
          r.sleep_cause = swc_pkg::CAUSE_STABLE;
        end
      end
    end else begin
      // One low-power leg: saturating total, then the wake reason by priority.
      sum       = {1'b0, ctl_total} + 33'(it.elapsed_ms);
      ctl_total = sum[32] ? '1 : sum[31:0];
      if (it.uart_rx_pending) begin
        r.wake_reason = swc_pkg::REASON_UART;
      end else if (ctl_cfg.rtc_wake_enable && it.rtc_fired) begin
        r.wake_reason = swc_pkg::REASON_RTC;
      end else if (it.button_held) begin
        r.wake_reason = swc_pkg::REASON_BTN;
      end else if (it.imu_int) begin
        r.wake_reason = swc_pkg::REASON_IMU;
      end else begin
        d = t - ctl_entry_temp;
        if (d < 0) d = -d;
        if (d >= int'(ctl_cfg.temp_wake_delta)) r.wake_reason = swc_pkg::REASON_TEMP;
      end
      if (r.wake_reason != swc_pkg::REASON_NONE) begin
        ctl_asleep    = 1'b0;
        ctl_win_armed = 1'b0;
      end
    end
    r.asleep_now      = ctl_asleep;
    r.asleep_total_ms = ctl_total;
    return r;
  endfunction

  function automatic swc_pkg::in_item_t mk_reading(logic [31:0] now, int temp, int held,
                                                   int press, int uart, int rtc, int imu,
                                                   logic [15:0] elapsed);
    swc_pkg::in_item_t it;
    it.now_ms             = now;
    it.temperature        = swc_pkg::temp_t'(temp);
    it.button_held        = held[0];
    it.button_press_event = press[0];
    it.uart_rx_pending    = uart[0];
    it.rtc_fired          = rtc[0];
    it.imu_int            = imu[0];
    it.elapsed_ms         = elapsed;
    return it;
  endfunction

  // Builds the next random transaction from the predicted mode. Polls follow a
  // running tick with readings near a slowly moving temperature and press-and-
  // hold sequences; legs mostly keep the entry temperature so a wake reason
  // comes from the flags or from an occasional large temperature change.
  function automatic swc_pkg::in_item_t next_reading();
    swc_pkg::in_item_t it;
    logic [31:0]       step;
    int                t;
    int                span;
    it = mk_reading($urandom(), 0, $urandom_range(1), $urandom_range(1), $urandom_range(1),
                    $urandom_range(1), $urandom_range(1), 16'($urandom()));
    if (ctl_asleep) begin
      case ($urandom_range(9))
        0:       it.elapsed_ms = '0;
        1:       it.elapsed_ms = '1;
        default: it.elapsed_ms = 16'($urandom());
      endcase
      it.uart_rx_pending = ($urandom_range(11) == 0);
      it.rtc_fired       = ($urandom_range(5) == 0);
      it.button_held     = ($urandom_range(11) == 0);
      it.imu_int         = ($urandom_range(11) == 0);
      if ($urandom_range(4) == 0) t = int'($urandom_range(T_MAX - T_MIN)) + T_MIN;
      else t = ctl_entry_temp + int'($urandom_range(4)) - 2;
    end else begin
      case ($urandom_range(15))
        0:       step = '0;
        1:       step = $urandom();
        default: step = $urandom_range(step_max);
      endcase
      gen_now   = gen_now + step;
      it.now_ms = gen_now;
      if ($urandom_range(15) == 0) gen_base = int'($urandom_range(T_MAX - T_MIN)) + T_MIN;
      span = int'(ctl_cfg.stable_range);
      t    = gen_base + int'($urandom_range(span)) - span / 2;
      if (hold_left == 0 && $urandom_range(7) == 0) begin
        it.button_press_event = 1'b1;
        hold_left             = $urandom_range(1, 10);
      end else begin
        it.button_press_event = ($urandom_range(19) == 0);
      end
      it.button_held = (hold_left > 0) ? ($urandom_range(15) != 0) : ($urandom_range(15) == 0);
      if (hold_left > 0) hold_left--;
    end
    if (t > T_MAX) t = T_MAX;
    else if (t < T_MIN) t = T_MIN;
    it.temperature = swc_pkg::temp_t'(t);
    return it;
  endfunction

  // Offers one transaction, possibly after random idle cycles, and records its
  // expected result once the block has taken it.
  task automatic offer_reading(input swc_pkg::in_item_t it);
    while ($urandom_range(99) < snd_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid              <= 1'b1;
    in_ch.now_ms             <= it.now_ms;
    in_ch.temperature        <= it.temperature;
    in_ch.button_held        <= it.button_held;
    in_ch.button_press_event <= it.button_press_event;
    in_ch.uart_rx_pending    <= it.uart_rx_pending;
    in_ch.rtc_fired          <= it.rtc_fired;
    in_ch.imu_int            <= it.imu_int;
    in_ch.elapsed_ms         <= it.elapsed_ms;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    predicted_status.push_back(predict_status(it));
  endtask

  // Stops offering, waits for every outstanding result, then lets the pipeline settle.
  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (predicted_status.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic put_reg(input swc_pkg::cfg_idx_t idx, input logic [31:0] data);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= data;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    case (idx)
      swc_pkg::REG_STABLE_RANGE:    ctl_cfg.stable_range    = data[7:0];
      swc_pkg::REG_STABLE_TIME_MS:  ctl_cfg.stable_time_ms  = data;
      swc_pkg::REG_TEMP_WAKE_DELTA: ctl_cfg.temp_wake_delta = data[11:0];
      swc_pkg::REG_LONGPRESS_MS:    ctl_cfg.longpress_ms    = data[15:0];
      swc_pkg::REG_RTC_WAKE_ENABLE: ctl_cfg.rtc_wake_enable = data[0];
      default: ;
    endcase
  endtask

  // Writes all registers back to back. With junk_high set, the bits above
  // each register's width carry random values that the block must drop.
  task automatic program_settings(input swc_pkg::cfg_t c, input bit junk_high);
    logic [31:0] junk;
    junk = junk_high ? $urandom() : 32'd0;
    put_reg(swc_pkg::REG_STABLE_RANGE,    {junk[31:8], c.stable_range});
    put_reg(swc_pkg::REG_STABLE_TIME_MS,  c.stable_time_ms);
    put_reg(swc_pkg::REG_TEMP_WAKE_DELTA, {junk[31:12], c.temp_wake_delta});
    put_reg(swc_pkg::REG_LONGPRESS_MS,    {junk[31:16], c.longpress_ms});
    put_reg(swc_pkg::REG_RTC_WAKE_ENABLE, {junk[31:1], c.rtc_wake_enable});
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic set_idling(input int snd_pct, input int rcv_pct);
    snd_idle_pct = snd_pct;
    rcv_idle_pct <= rcv_pct;
  endtask

  // ---------------------------------------------------------------------------
  // Result side: random stalls, plus one long hold-off counted here.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rx_hold) begin
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= rcv_idle_pct);
    end
  end

  initial forever begin
    @(hold_kick);
    rx_hold <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    rx_hold <= 1'b0;
  end

  task automatic note_mismatch(input string field, input logic [31:0] expv,
                               input logic [31:0] actv);
    $display("%0t: %s mismatch, expected %0d actual %0d", $time, field, expv, actv);
    mismatches++;
  endtask

  // Every result transaction is compared field by field with the oldest
  // prediction. A result with nothing predicted is a failure on its own.
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (predicted_status.size() == 0) begin
        $display("%0t: unexpected result, expected none actual total %0d", $time,
                 out_ch.asleep_total_ms);
        mismatches++;
      end else begin
        exp_status = predicted_status.pop_front();
        if (exp_status.asleep_now !== out_ch.asleep_now)
          note_mismatch("asleep_now", 32'(exp_status.asleep_now), 32'(out_ch.asleep_now));
        if (exp_status.enter_sleep !== out_ch.enter_sleep)
          note_mismatch("enter_sleep", 32'(exp_status.enter_sleep), 32'(out_ch.enter_sleep));
        if (exp_status.sleep_cause !== out_ch.sleep_cause)
          note_mismatch("sleep_cause", 32'(exp_status.sleep_cause), 32'(out_ch.sleep_cause));
        if (exp_status.wake_reason !== out_ch.wake_reason)
          note_mismatch("wake_reason", 32'(exp_status.wake_reason), 32'(out_ch.wake_reason));
        if (exp_status.asleep_total_ms !== out_ch.asleep_total_ms)
          note_mismatch("asleep_total_ms", exp_status.asleep_total_ms,
                        out_ch.asleep_total_ms);
      end
    end
  end

  // A hang anywhere ends the run here.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb_sleep_entry_wake_controller_unit failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // With the reset settings: window arming and restart on the temperature
  // extremes, a long press that puts the block to sleep, legs that ignore the
  // press and the tick, RTC ignored while disabled, a wake on a temperature
  // change of exactly the delta, the stable-window sleep, UART priority over
  // the button and IMU, and a press timer that expires across the tick wrap
  // with the button already released.
  task automatic test_long_press_and_stable_sleep();
    set_idling(19, 73);
    offer_reading(mk_reading(32'd0,     0,     0, 0, 1, 1, 1, 16'hFFFF));
    offer_reading(mk_reading(32'd100,   T_MIN, 0, 0, 0, 0, 0, 16'd0));
    offer_reading(mk_reading(32'd200,   T_MAX, 0, 0, 0, 0, 0, 16'd0));
    offer_reading(mk_reading(32'd1000,  T_MAX, 1, 1, 0, 0, 0, 16'd0));
    offer_reading(mk_reading(32'd4000,  T_MAX, 1, 0, 0, 0, 0, 16'd0));
    offer_reading(mk_reading('1,        T_MAX, 0, 1, 0, 0, 0, 16'hFFFF));
    offer_reading(mk_reading(32'd0,     T_MAX, 0, 0, 0, 1, 0, 16'd0));
    offer_reading(mk_reading(32'd0,     T_MAX - 10, 0, 0, 0, 0, 0, 16'd100));
    offer_reading(mk_reading(32'd5000,  100,   0, 0, 0, 0, 0, 16'd0));
    offer_reading(mk_reading(32'd65000, 105,   0, 0, 0, 0, 0, 16'd0));
    offer_reading(mk_reading(32'd0,     105,   1, 0, 1, 1, 1, 16'd5));
    offer_reading(mk_reading(32'hFFFF_FFF0, 0, 1, 1, 0, 0, 0, 16'd0));
    offer_reading(mk_reading(32'h0000_0B00, 0, 0, 0, 0, 0, 0, 16'd0));
    offer_reading(mk_reading(32'h0000_0BA8, 0, 0, 0, 0, 0, 0, 16'd0));
  endtask

  // Lowest times and thresholds with the widest spread: a spread of exactly
  // the range still counts as stable, a zero stable time sleeps on the first
  // poll of an armed window, a zero long-press time expires on the next poll,
  // the RTC wakes once enabled, and a zero wake delta wakes on any leg.
  task automatic test_register_extremes();
    wait_idle();
    program_settings('{stable_range: 8'd255, stable_time_ms: 32'd0, temp_wake_delta: 12'd0,
                       longpress_ms: 16'd0, rtc_wake_enable: 1'b1}, 1'b0);
    offer_reading(mk_reading(32'd50, T_MIN,       0, 0, 0, 0, 0, 16'd0));
    offer_reading(mk_reading(32'd50, T_MIN + 255, 1, 1, 0, 0, 0, 16'd0));
    offer_reading(mk_reading(32'd0,  T_MAX,       0, 0, 0, 1, 0, 16'd1));
    offer_reading(mk_reading(32'd50, 0,           1, 0, 0, 0, 0, 16'd0));
    offer_reading(mk_reading(32'd0,  0,           1, 0, 0, 0, 1, 16'd2));
    offer_reading(mk_reading(32'd7,  0,           0, 1, 0, 0, 0, 16'd0));
    offer_reading(mk_reading(32'd7,  0,           0, 0, 0, 0, 0, 16'd0));
    offer_reading(mk_reading(32'd0,  0,           0, 0, 0, 0, 1, 16'd3));
    offer_reading(mk_reading(32'd9,  0,           0, 0, 0, 0, 0, 16'd0));
    offer_reading(mk_reading(32'd9,  0,           0, 0, 0, 0, 0, 16'd0));
    offer_reading(mk_reading(32'd0,  0,           0, 0, 0, 0, 0, 16'd4));
  endtask

  // One random phase under one register setting and one idling pattern.
  task automatic test_random_traffic(input swc_pkg::cfg_t c, input bit junk_high,
                                     input int count, input int snd_pct, input int rcv_pct,
                                     input logic [31:0] max_step);
    wait_idle();
    program_settings(c, junk_high);
    set_idling(snd_pct, rcv_pct);
    step_max = max_step;
    repeat (count) offer_reading(next_reading());
  endtask

  // The receiver stops for a long stretch while the sender keeps offering,
  // so both internal registers fill up and the input must stall.
  task automatic test_backpressure();
    set_idling(0, 0);
    -> hold_kick;
    repeat (40) offer_reading(next_reading());
  endtask

  // A long sleep of full-length legs, so the total grows far past the range
  // of a single leg, then a UART wake to leave it.
  task automatic test_long_sleep_total();
    wait_idle();
    program_settings('{stable_range: 8'd255, stable_time_ms: 32'd0, temp_wake_delta: 12'd100,
                       longpress_ms: 16'hFFFF, rtc_wake_enable: 1'b0}, 1'b0);
    set_idling(0, 0);
    while (!ctl_asleep) offer_reading(mk_reading(gen_now, 0, 0, 0, 0, 0, 0, 16'd0));
    repeat (60) offer_reading(mk_reading('0, ctl_entry_temp, 0, 0, 0, 0, 0, 16'hFFFF));
    offer_reading(mk_reading('0, ctl_entry_temp, 0, 0, 1, 0, 0, 16'hFFFF));
  endtask

  initial begin
    // Every block input is known from time zero.
    rst_n                    = 1'b0;
    in_ch.valid              = 1'b0;
    in_ch.now_ms             = '0;
    in_ch.temperature        = '0;
    in_ch.button_held        = 1'b0;
    in_ch.button_press_event = 1'b0;
    in_ch.uart_rx_pending    = 1'b0;
    in_ch.rtc_fired          = 1'b0;
    in_ch.imu_int            = 1'b0;
    in_ch.elapsed_ms         = '0;
    out_ch.ready             = 1'b0;
    cfg_ch.valid             = 1'b0;
    cfg_ch.index             = '0;
    cfg_ch.data              = '0;

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    test_long_press_and_stable_sleep();
    test_register_extremes();

    // Random phases: reset values, mid-range values with junk in the unused
    // data bits, the upper extremes with junk as well, and the lower extremes.
    test_random_traffic('{stable_range: 8'd10, stable_time_ms: 32'd60000,
                          temp_wake_delta: 12'd10, longpress_ms: 16'd3000,
                          rtc_wake_enable: 1'b0}, 1'b0, 300, 19, 73, 32'd8000);
    test_random_traffic('{stable_range: 8'd20, stable_time_ms: 32'd2000,
                          temp_wake_delta: 12'd30, longpress_ms: 16'd500,
                          rtc_wake_enable: 1'b1}, 1'b1, 300, 73, 19, 32'd400);
    test_random_traffic('{stable_range: 8'd255, stable_time_ms: 32'hFFFF_FFFF,
                          temp_wake_delta: 12'hFFF, longpress_ms: 16'hFFFF,
                          rtc_wake_enable: 1'b0}, 1'b1, 300, 0, 0, 32'd30000);
    test_random_traffic('{stable_range: 8'd0, stable_time_ms: 32'd0,
                          temp_wake_delta: 12'd0, longpress_ms: 16'd0,
                          rtc_wake_enable: 1'b1}, 1'b0, 280, 0, 0, 32'd50);
    test_backpressure();
    test_long_sleep_total();

    wait_idle();
    if (mismatches == 0) begin
      $display("tb_sleep_entry_wake_controller_unit passed");
    end else begin
      $display("tb_sleep_entry_wake_controller_unit failed");
    end
    $finish;
  end

endmodule
